// ===== rtl/core/sdta_pkg.sv =====
// shared types and constants for the signed decimal to ascii formatter
package sdta_pkg;

    localparam int MAG_W         = 32;
    localparam int DIGIT_W       = 4;
    localparam int NUM_DIGITS    = 10;
    localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = MAG_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(CONV_STEPS);
    localparam int IDX_W         = $clog2(NUM_DIGITS);
    localparam int CNT_W         = $clog2(NUM_DIGITS + 1);
    localparam int SHAMT_W       = $clog2(BCD_W);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // classified word: sign and unsigned magnitude
    typedef struct packed {
        logic             negative;
        logic [MAG_W-1:0] magnitude;
    } item_t;

    // converted word: sign and packed bcd digits, least significant digit lowest
    typedef struct packed {
        logic             negative;
        logic [BCD_W-1:0] bcd;
    } digits_t;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_RUN,
        CONV_DONE
    } conv_state_t;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_SIGN,
        EMIT_DIGIT
    } emit_state_t;

endpackage

// ===== rtl/core/sdta_front.sv =====
// front stage: takes a word, splits it into sign and magnitude
module sdta_front
    import sdta_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic signed [MAG_W-1:0] value,
    output logic              push_valid,
    input  logic              push_ready,
    output item_t             push_item
);

    logic  hold_valid_reg;
    logic  hold_valid_next;
    item_t item_reg;
    item_t item_next;
    logic [MAG_W-1:0] raw;

    assign raw        = $unsigned(value);
    assign in_ready   = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        item_next       = item_reg;
        if (push_valid && push_ready)
        begin
            hold_valid_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            hold_valid_next     = 1'b1;
            item_next.negative  = raw[MAG_W-1];
            // two's complement magnitude, most negative value stays 2^31 unsigned
            item_next.magnitude = raw[MAG_W-1] ? (~raw + MAG_W'(1)) : raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ===== rtl/core/sdta_queue.sv =====
// short fifo between the front stage and the converter
module sdta_queue
    import sdta_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/sdta_conv.sv =====
// binary to bcd converter, shift-and-add-3 over several bits per cycle
module sdta_conv
    import sdta_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pop_valid,
    output logic    pop_ready,
    input  item_t   pop_item,
    output logic    conv_valid,
    input  logic    conv_ready,
    output digits_t conv_digits
);

    conv_state_t       state_reg;
    conv_state_t       state_next;
    logic [MAG_W-1:0]  mag_reg;
    logic [MAG_W-1:0]  mag_next;
    logic [BCD_W-1:0]  bcd_reg;
    logic [BCD_W-1:0]  bcd_next;
    logic              neg_reg;
    logic              neg_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [BCD_W-1:0]  bcd_stepped;

    // one bit of double dabble: correct digits of five or more, then shift in
    function automatic logic [BCD_W-1:0] dabble_bit(input logic [BCD_W-1:0] bcd,
                                                    input logic din);
        logic [BCD_W-1:0]   adj;
        logic [DIGIT_W-1:0] d;
        adj = bcd;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            d = bcd[i*DIGIT_W +: DIGIT_W];
            if (d >= DIGIT_W'(5))
            begin
                adj[i*DIGIT_W +: DIGIT_W] = d + DIGIT_W'(3);
            end
        end
        return {adj[BCD_W-2:0], din};
    endfunction

    always_comb
    begin
        bcd_stepped = bcd_reg;
        for (int j = 0; j < BITS_PER_STEP; j++)
        begin
            bcd_stepped = dabble_bit(bcd_stepped, mag_reg[MAG_W-1-j]);
        end
    end

    assign conv_valid           = (state_reg == CONV_DONE);
    assign conv_digits.negative = neg_reg;
    assign conv_digits.bcd      = bcd_reg;
    assign pop_ready            = (state_reg == CONV_IDLE) ||
                                  ((state_reg == CONV_DONE) && conv_ready);

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        step_next  = step_reg;
        case (state_reg)
            CONV_IDLE, CONV_DONE:
            begin
                if ((state_reg == CONV_DONE) && conv_ready)
                begin
                    state_next = CONV_IDLE;
                end
                if (pop_valid && pop_ready)
                begin
                    state_next = CONV_RUN;
                    mag_next   = pop_item.magnitude;
                    neg_next   = pop_item.negative;
                    bcd_next   = '0;
                    step_next  = '0;
                end
            end
            CONV_RUN:
            begin
                bcd_next  = bcd_stepped;
                mag_next  = mag_reg << BITS_PER_STEP;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(CONV_STEPS - 1))
                begin
                    state_next = CONV_DONE;
                end
            end
            default:
            begin
                state_next = CONV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CONV_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

endmodule

// ===== rtl/core/sdta_emit.sv =====
// character emitter: sign for negative numbers, then digits from the leading nonzero one
module sdta_emit
    import sdta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       conv_valid,
    output logic       conv_ready,
    input  digits_t    conv_digits,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] text_char,
    output logic       last_char
);

    emit_state_t        state_reg;
    emit_state_t        state_next;
    logic [BCD_W-1:0]   bcd_reg;
    logic [BCD_W-1:0]   bcd_next;
    logic [CNT_W-1:0]   left_reg;
    logic [CNT_W-1:0]   left_next;
    logic [IDX_W-1:0]   msd;
    logic [SHAMT_W-1:0] shamt;
    logic               finishing;

    // position of the leading nonzero digit, zero gives the ones digit
    always_comb
    begin
        msd = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (conv_digits.bcd[i*DIGIT_W +: DIGIT_W] != '0)
            begin
                msd = IDX_W'(i);
            end
        end
        shamt = SHAMT_W'((NUM_DIGITS - 1 - int'(msd)) * DIGIT_W);
    end

    assign out_valid  = (state_reg != EMIT_IDLE);
    assign last_char  = (state_reg == EMIT_DIGIT) && (left_reg == CNT_W'(1));
    assign text_char  = (state_reg == EMIT_SIGN) ? CHAR_MINUS :
                        (CHAR_ZERO | {4'b0000, bcd_reg[BCD_W-1 -: DIGIT_W]});
    assign finishing  = out_valid && out_ready && last_char;
    assign conv_ready = (state_reg == EMIT_IDLE) || finishing;

    always_comb
    begin
        state_next = state_reg;
        bcd_next   = bcd_reg;
        left_next  = left_reg;
        case (state_reg)
            EMIT_IDLE:
            begin
            end
            EMIT_SIGN:
            begin
                if (out_ready)
                begin
                    state_next = EMIT_DIGIT;
                end
            end
            EMIT_DIGIT:
            begin
                if (out_ready)
                begin
                    bcd_next  = bcd_reg << DIGIT_W;
                    left_next = left_reg - CNT_W'(1);
                    if (left_reg == CNT_W'(1))
                    begin
                        state_next = EMIT_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = EMIT_IDLE;
            end
        endcase
        if (conv_valid && conv_ready)
        begin
            state_next = conv_digits.negative ? EMIT_SIGN : EMIT_DIGIT;
            bcd_next   = conv_digits.bcd << shamt;
            left_next  = CNT_W'(msd) + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EMIT_IDLE;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
    end

endmodule

// ===== rtl/core/signed_decimal_to_ascii.sv =====
// top level of the signed 32-bit integer to decimal ascii formatter
//
// Each input word is a signed 32-bit integer; the block answers with its decimal
// text, one ascii character per output word, most significant first. Negative
// numbers lead with '-', leading zeros never appear, zero gives the single
// character '0', and the most negative value prints as -2147483648 (eleven
// characters). last_char marks the final character of each number. Both sides
// use valid/ready and a word moves when both are high. Inside, a front stage
// registers the word and splits it into sign and magnitude, a two-entry queue
// decouples it from the back end, a double-dabble converter turns the magnitude
// into bcd four bits per cycle, and the emitter streams the characters one per
// cycle while out_ready is high. The converter works on the next number while
// the emitter is still sending the current one.
module signed_decimal_to_ascii
    import sdta_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // input channel
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [MAG_W-1:0] value,
    // output channel
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              text_char,
    output logic                    last_char
);

    // front to queue
    logic    push_valid;
    logic    push_ready;
    item_t   push_item;
    // queue to converter
    logic    pop_valid;
    logic    pop_ready;
    item_t   pop_item;
    // converter to emitter
    logic    conv_valid;
    logic    conv_ready;
    digits_t conv_digits;

    // sign/magnitude split
    sdta_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // lets the front keep taking words while the back end is busy
    sdta_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // magnitude to bcd
    sdta_conv u_conv
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_item    (pop_item),
        .conv_valid  (conv_valid),
        .conv_ready  (conv_ready),
        .conv_digits (conv_digits)
    );

    // bcd to character stream
    sdta_emit u_emit
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .conv_valid  (conv_valid),
        .conv_ready  (conv_ready),
        .conv_digits (conv_digits),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .text_char   (text_char),
        .last_char   (last_char)
    );

endmodule

// ===== verif/sdta_tb_pkg.sv =====
// scoreboard that predicts and checks the decimal text of each signed word
`timescale 1ns / 100ps

package sdta_tb_pkg;

    import sdta_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
    } char_word_t;

    class text_scoreboard;

        char_word_t expected_chars[$];
        int         fail_count;
        int         numbers_seen;
        int         negatives_seen;
        int         eleven_char_seen;
        int         chars_seen;

        function new();
            fail_count       = 0;
            numbers_seen     = 0;
            negatives_seen   = 0;
            eleven_char_seen = 0;
            chars_seen       = 0;
        endfunction

        task report(input string msg);
            fail_count++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        function int pending();
            return expected_chars.size();
        endfunction

        // decimal text of one accepted word, most significant digit first
        function void note_value(input logic [MAG_W-1:0] word);
            logic             negative;
            logic [MAG_W-1:0] magnitude;
            logic [3:0]       digit_val [NUM_DIGITS];
            int               n_digits;
            negative  = word[MAG_W-1];
            magnitude = negative ? (~word + 1'b1) : word;
            n_digits  = 0;
            do begin
                digit_val[n_digits] = 4'(magnitude % 10);
                n_digits++;
                magnitude = magnitude / 10;
            end while (magnitude != 0 && n_digits < NUM_DIGITS);
            if (negative)
            begin
                expected_chars.push_back('{ch: CHAR_MINUS, is_last: 1'b0});
                negatives_seen++;
            end
            for (int i = n_digits - 1; i >= 0; i--)
            begin
                expected_chars.push_back('{ch: CHAR_ZERO + 8'(digit_val[i]),
                                           is_last: (i == 0)});
            end
            numbers_seen++;
            if (n_digits + (negative ? 1 : 0) == NUM_DIGITS + 1)
                eleven_char_seen++;
        endfunction

        task check_char(input logic [7:0] got_char, input logic got_last);
            char_word_t exp_word;
            chars_seen++;
            if (expected_chars.size() == 0)
            begin
                report($sformatf("unexpected char 0x%02h last %b", got_char, got_last));
                return;
            end
            exp_word = expected_chars.pop_front();
            if (got_char !== exp_word.ch)
                report($sformatf("text_char 0x%02h, expected 0x%02h", got_char, exp_word.ch));
            if (got_last !== exp_word.is_last)
                report($sformatf("last_char %b, expected %b on char 0x%02h",
                                 got_last, exp_word.is_last, exp_word.ch));
        endtask

    endclass

endpackage

// ===== verif/tb_top.sv =====
// top level testbench for the signed decimal to ascii formatter
`timescale 1ns / 100ps

module tb_top;

    import sdta_pkg::*;
    import sdta_tb_pkg::*;

    // cycles with no word moving on either side before the run is declared hung
    localparam int QUIET_LIMIT  = 2000;
    // long receiver hold-off, well beyond what the block can buffer
    localparam int HOLD_CYCLES  = 400;
    // wait after the drain; a number gives up to 11 chars
    localparam int DRAIN_CYCLES = 40;

    // hand-picked words: zero, sign flips, digit-count boundaries, both extremes
    localparam logic [MAG_W-1:0] DIRECTED_VALUES [22] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'd9, -32'sd9,
        32'd10, -32'sd10, 32'd99, 32'd100, 32'd999999999,
        32'd1000000000, -32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'd123456789,
        -32'sd123456789, 32'd1000000001, 32'd7, 32'h0000_0100
    };

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [MAG_W-1:0] value;
    logic                    out_valid;
    logic                    out_ready;
    logic [7:0]              text_char;
    logic                    last_char;

    text_scoreboard sb;

    // idle odds in percent per cycle, set per phase by the main sequence
    int send_idle_pct;
    int recv_idle_pct;
    // nonzero asks the receiver process to hold off for that many cycles
    int hold_request;
    int hold_count;
    int quiet_cycles;
    int input_stall_cycles;

    signed_decimal_to_ascii dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .text_char (text_char),
        .last_char (last_char)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // sample both channels at the rising edge, after the block has settled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_value(value);
            if (in_valid && !in_ready)
                input_stall_cycles++;
            if (out_valid && out_ready)
                sb.check_char(text_char, last_char);
        end
    end

    // hang detection: count edges where no word moves on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[%0t] no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random back-pressure, plus a long hold-off on request
    initial
    begin
        out_ready  = 1'b0;
        hold_count = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_count   = hold_request;
                hold_request = 0;
            end
            if (!rst_n)
                out_ready <= 1'b0;
            else if (hold_count > 0)
            begin
                out_ready <= 1'b0;
                hold_count--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one word, with a random gap first; returns at the falling edge
    // after the accept with valid still high, so back-to-back words never
    // drop valid for a step
    task automatic send_value(input logic [MAG_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= word;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // random words, biased toward digit-count boundaries and the extremes
    task automatic run_random(input int count);
        logic [MAG_W-1:0] pick;
        int unsigned      scale;
        for (int i = 0; i < count; i++)
        begin
            scale = 1;
            case ($urandom_range(3))
                0: pick = $urandom();
                1:
                begin
                    // random number of digits, random sign
                    repeat ($urandom_range(1, 9)) scale = scale * 10;
                    pick = $urandom() % scale;
                    if ($urandom_range(1))
                        pick = -pick;
                end
                2:
                begin
                    // right around a power of ten, where the digit count flips
                    repeat ($urandom_range(0, 9)) scale = scale * 10;
                    pick = scale + $urandom_range(2) - 1;
                    if ($urandom_range(1))
                        pick = -pick;
                end
                default:
                begin
                    case ($urandom_range(3))
                        0:       pick = 32'h8000_0000;
                        1:       pick = 32'h7FFF_FFFF;
                        2:       pick = '0;
                        default: pick = 32'h8000_0001;
                    endcase
                end
            endcase
            send_value(pick);
        end
    endtask

    // stop offering and wait until every expected char has come out
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        sb                 = new();
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        value              = '0;
        send_idle_pct      = 38;
        recv_idle_pct      = 47;
        hold_request       = 0;
        quiet_cycles       = 0;
        input_stall_cycles = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed words first, receiver idles more than the sender
        foreach (DIRECTED_VALUES[i])
            send_value(DIRECTED_VALUES[i]);
        run_random(160);

        // receiver holds off while the sender keeps offering: the block fills
        // and has to stall its input
        send_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        run_random(24);

        // sender pauses until every char has come out
        send_idle_pct = 38;
        wait_for_drain();

        // roles swapped: sender idles more than the receiver
        send_idle_pct = 47;
        recv_idle_pct = 38;
        run_random(140);

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(130);

        wait_for_drain();
        // anything the block still sends now shows up as an unexpected char
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d numbers (%0d negative, %0d of eleven chars), %0d chars checked",
                 sb.numbers_seen, sb.negatives_seen, sb.eleven_char_seen, sb.chars_seen);
        $display("input held back on %0d cycles, %0d mismatches",
                 input_stall_cycles, sb.fail_count);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected chars never came out", sb.pending()));
        if (sb.fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sdta_pkg.sv
rtl/core/sdta_front.sv
rtl/core/sdta_queue.sv
rtl/core/sdta_conv.sv
rtl/core/sdta_emit.sv
rtl/core/signed_decimal_to_ascii.sv
verif/sdta_tb_pkg.sv
verif/tb_top.sv
